/* hw/rtl/fwsd_pkg.sv */
package fwsd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 1 + STATUS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_ABSENT     = 3'd2,
    STAT_TAIL_MATCH = 3'd3,
    STAT_FULL_DROP  = 3'd4
  } status_e;

  typedef struct packed {
    logic cmp;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* hw/rtl/fwsd_cell.sv */
module fwsd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fwsd_pkg::cell_ctrl_t       ctrl_i,
  input  logic                       held_i,
  input  logic [fwsd_pkg::DATA_W-1:0] value_i,
  input  logic [fwsd_pkg::DATA_W-1:0] next_data_i,
  input  logic                       next_hit_i,
  output logic [fwsd_pkg::DATA_W-1:0] data_o,
  output logic                       hit_o
);
  import fwsd_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic              hit_q, hit_d;

  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    if (ctrl_i.shift) begin
      data_d = next_data_i;
      hit_d  = next_hit_i;
    end else begin
      if (ctrl_i.load) data_d = value_i;
      if (ctrl_i.cmp) hit_d = held_i & (data_q == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

/* hw/rtl/fifo_with_search_and_drop_through.sv */
// Bounded FIFO of signed 32-bit values with content search. Each input transaction carries an
// operation in tuser (0 push, 1 remove through first match, 2 search; 3 acts as search) and the
// value in tdata. Each produces one output transaction: tuser holds found (bit 0) and status
// (bits 3:1: 0 ok, 1 empty, 2 absent, 3 refused tail match, 4 full drop), tdata holds the
// occupancy after the operation in its low 5 bits. Entries live in a row of cells with the head
// in the first cell; all cells compare against the value in parallel. An item goes through
// accept, compare, decide and result; a successful remove adds one shift per dropped entry,
// as the row shifts toward the head by one cell a cycle. Input is taken only between items;
// a finished result waits in the output register without holding up the next input.
module fifo_with_search_and_drop_through #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [fwsd_pkg::DATA_W-1:0]     s_axis_tdata_i,  // value
  input  logic [fwsd_pkg::OP_W-1:0]       s_axis_tuser_i,  // op
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [fwsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // occupancy, zero padded
  output logic [fwsd_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o  // found, status
);
  import fwsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CMP    = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              found_q, found_d;
  status_e           status_q, status_d;

  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  status_e           out_status_q, out_status_d;
  logic [OCC_W-1:0]  out_occ_q, out_occ_d;

  logic [DATA_W-1:0]      cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit_w;
  logic                   found_w;
  logic                   tail_hit;
  logic [CNT_W-1:0]       cnt_m1;
  logic                   push_wr;
  logic                   in_txn;

  assign found_w  = |hit_w;
  assign cnt_m1   = count_q - CNT_W'(1);
  assign tail_hit = hit_w[cnt_m1[IDX_W-1:0]];
  assign in_txn   = s_axis_tvalid_i & s_axis_tready_o;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] nxt_data;
    logic              nxt_hit;

    assign ctrl.cmp   = (state_q == ST_CMP);
    assign ctrl.shift = (state_q == ST_SHIFT);
    assign ctrl.load  = push_wr & (count_q == CNT_W'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_data = cell_data[i];
      assign nxt_hit  = 1'b0;
    end else begin : g_mid
      assign nxt_data = cell_data[i+1];
      assign nxt_hit  = hit_w[i+1];
    end

    fwsd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .held_i      (CNT_W'(i) < count_q),
      .value_i     (value_q),
      .next_data_i (nxt_data),
      .next_hit_i  (nxt_hit),
      .data_o      (cell_data[i]),
      .hit_o       (hit_w[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    value_d      = value_q;
    count_d      = count_q;
    found_d      = found_q;
    status_d     = status_q;
    push_wr      = 1'b0;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_txn) begin
          op_d    = op_e'(s_axis_tuser_i);
          value_d = s_axis_tdata_i;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        found_d  = found_w;
        status_d = STAT_OK;
        state_d  = ST_RESP;
        unique case (op_q)
          OP_PUSH: begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = STAT_FULL_DROP;
            end else begin
              push_wr = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            priority if (count_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (!found_w) begin
              status_d = STAT_ABSENT;
            end else if (tail_hit) begin
              status_d = STAT_TAIL_MATCH;
            end else begin
              state_d = ST_SHIFT;
            end
          end
          default: ;
        endcase
      end
      ST_SHIFT: begin
        count_d = cnt_m1;
        if (hit_w[0]) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_found_d  = found_q;
          out_status_d = status_q;
          out_occ_d    = OCC_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    found_q      <= found_d;
    status_q     <= status_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_occ_q);
  assign m_axis_tuser_o  = {out_status_q, out_found_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_full_drop_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_FULL_DROP) |-> (out_occ_q == OCC_W'(QUEUE_DEPTH)))
    else $error("full drop reported while not full");

  a_tail_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_TAIL_MATCH || out_status_q == STAT_ABSENT))
      |-> (out_found_q == (out_status_q == STAT_TAIL_MATCH)))
    else $error("found flag disagrees with remove status");

  a_shift_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (count_q != '0))
    else $error("shift with empty queue");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

typedef struct {
  logic                found;
  fwsd_pkg::status_e   status;
  logic [4:0]          occ;
} fifo_result_t;

class fifo_scoreboard;
  int unsigned  depth;
  logic [31:0]  held[$];
  fifo_result_t due[$];
  int           errors;

  function new(int unsigned d);
    depth  = d;
    errors = 0;
  endfunction

  // mirror one accepted transaction and queue its expected result
  function void note_item(logic [1:0] op, logic [31:0] value);
    int           k;
    fifo_result_t r;
    k = held.size();
    for (int i = 0; i < held.size(); i++) begin
      if (held[i] == value) begin
        k = i;
        break;
      end
    end
    r.found  = (k < held.size());
    r.status = fwsd_pkg::STAT_OK;
    case (op)
      fwsd_pkg::OP_PUSH: begin
        if (held.size() >= depth) r.status = fwsd_pkg::STAT_FULL_DROP;
        else held.push_back(value);
      end
      fwsd_pkg::OP_REMOVE: begin
        if (held.size() == 0) r.status = fwsd_pkg::STAT_EMPTY;
        else if (!r.found) r.status = fwsd_pkg::STAT_ABSENT;
        else if (held[$] == value) r.status = fwsd_pkg::STAT_TAIL_MATCH;
        else repeat (k + 1) void'(held.pop_front());
      end
      default: ;
    endcase
    r.occ = 5'(held.size());
    due.push_back(r);
  endfunction

  function void check_result(logic [7:0] tdata, logic [3:0] tuser);
    fifo_result_t r;
    if (due.size() == 0) begin
      $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
               $time, tdata, tuser);
      errors++;
      return;
    end
    r = due.pop_front();
    if (tuser[0] !== r.found) begin
      $display("%0t: found mismatch, expected %0b, got %0b", $time, r.found, tuser[0]);
      errors++;
    end
    if (tuser[3:1] !== r.status) begin
      $display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, tuser[3:1]);
      errors++;
    end
    if (tdata !== {3'b000, r.occ}) begin
      $display("%0t: occupancy mismatch, expected %0d, got %h", $time, r.occ, tdata);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import fwsd_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam logic [1:0]  OP_SPARE  = 2'd3;
  localparam int          PHASE_LEN = 242;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [DATA_W-1:0]      s_axis_tdata_i = '0;
  logic [OP_W-1:0]        s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;

  int tx_idle_pct = 30;
  int rx_idle_pct = 59;

  fifo_scoreboard sb = new(DEPTH);

  fifo_with_search_and_drop_through #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic send_item(logic [1:0] op, logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(op, value);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom;
      4:       return 32'hffff_fff0 | $urandom_range(15);
      default: return $urandom_range(11);
    endcase
  endfunction

  task automatic random_items(int count);
    int          r;
    int          push_pct;
    logic [1:0]  op;
    logic [31:0] value;
    for (int i = 0; i < count; i++) begin
      push_pct = ((i / 40) % 2) ? 70 : 30;
      r = $urandom_range(99);
      value = pick_value();
      if (r < push_pct) begin
        op = OP_PUSH;
      end else if (r < push_pct + (100 - push_pct) / 2) begin
        op = OP_REMOVE;
        if (sb.held.size() != 0 && $urandom_range(9) < 7)
          value = sb.held[$urandom_range(sb.held.size() - 1)];
      end else if (r < 95) begin
        op = OP_SEARCH;
        if (sb.held.size() != 0 && $urandom_range(1))
          value = sb.held[$urandom_range(sb.held.size() - 1)];
      end else begin
        op = OP_SPARE;
      end
      send_item(op, value);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue cases
    send_item(OP_REMOVE, 32'd5);
    send_item(OP_SEARCH, 32'd5);
    send_item(OP_SPARE,  32'd5);
    // field extremes
    send_item(OP_PUSH,   32'h8000_0000);
    send_item(OP_PUSH,   32'h7fff_ffff);
    send_item(OP_PUSH,   32'h0000_0000);
    send_item(OP_PUSH,   32'hffff_ffff);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h0001_2345);
    send_item(OP_REMOVE, 32'h0001_2345);
    // tail match refused, also with an earlier match
    send_item(OP_REMOVE, 32'hffff_ffff);
    send_item(OP_PUSH,   32'h7fff_ffff);
    send_item(OP_REMOVE, 32'h7fff_ffff);
    // drop through head, then through a middle entry
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_SPARE,  32'hffff_ffff);
    // fill, overflow, then a long drop
    for (int i = 0; i < 14; i++) send_item(OP_PUSH, 32'd100 + i);
    send_item(OP_PUSH,   32'd101);
    send_item(OP_REMOVE, 32'd112);
    drain();

    random_items(PHASE_LEN);
    drain();
    tx_idle_pct = 59;
    rx_idle_pct = 30;
    random_items(PHASE_LEN);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(PHASE_LEN);
    drain();

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_top: errors");
    $finish;
  end
endmodule
